// ===== hdl/wenoz_pkg.sv =====
// Shared types and widths for the WENO-Z+ face reconstruction pipeline.
package wenoz_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int SW = 32;

  localparam int WEIGHT_BITS = 30;
  localparam int IND_FRAC    = 16;
  localparam int MAG_LIMIT   = 29;
  localparam int B_W         = 64;

  typedef struct packed {
    logic signed [SW-1:0] sample_minus_two;
    logic signed [SW-1:0] sample_minus_one;
    logic signed [SW-1:0] sample_centre;
    logic signed [SW-1:0] sample_plus_one;
    logic signed [SW-1:0] sample_plus_two;
  } in_req_t;

  typedef struct packed {
    logic signed [SW-1:0] upper_face_value;
    logic signed [SW-1:0] lower_face_value;
  } out_req_t;

endpackage

// ===== hdl/wenoz_divider.sv =====
// Pipelined restoring fraction divider: floor(num * 2^FB / den), saturated to cap.
module wenoz_divider #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int FB = 16,
  parameter int CW = 31
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [CW-1:0] cap,
  output logic [CW-1:0] quo
);
  localparam int QW = NW + FB;
  localparam int ST = QW;

  logic [QW-1:0]   rem_r [ST+1];
  logic [QW-1:0]   q_r   [ST+1];
  logic [DW-1:0]   den_r [ST+1];
  logic [CW-1:0]   cap_r [ST+1];

  assign rem_r[0] = '0;
  assign q_r[0]   = {num, {FB{1'b0}}};
  assign den_r[0] = den;
  assign cap_r[0] = cap;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < ST; i++) begin : g_step
    logic [QW:0]   trial;
    logic [QW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;
    logic [QW-1:0] rem_st_r, q_st_r;
    logic [DW-1:0] den_st_r;
    logic [CW-1:0] cap_st_r;
    always_comb begin
      trial   = {rem_r[i], q_r[i][QW-1]};
      q_nxt   = {q_r[i][QW-2:0], 1'b0};
      rem_nxt = trial[QW-1:0];
      if (trial >= {{(QW+1-DW){1'b0}}, den_r[i]}) begin
        rem_nxt  = QW'(trial - {{(QW+1-DW){1'b0}}, den_r[i]});
        q_nxt[0] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_st_r <= rem_nxt;
        q_st_r   <= q_nxt;
        den_st_r <= den_r[i];
        cap_st_r <= cap_r[i];
      end
    end
    assign rem_r[i+1] = rem_st_r;
    assign q_r[i+1]   = q_st_r;
    assign den_r[i+1] = den_st_r;
    assign cap_r[i+1] = cap_st_r;
  end

  // quotient grows monotonically, so a final compare equals the early exit
  assign quo = (q_r[ST] > {{(QW-CW){1'b0}}, cap_r[ST]}) ? cap_r[ST] : q_r[ST][CW-1:0];
endmodule

// ===== hdl/wenoz_face.sv =====
// One face reconstruction: candidates, smoothness, indicators, weights, blend.
module wenoz_face #(
  parameter int SAMPLE_WIDTH = wenoz_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic                           fd,
  input  logic signed [SAMPLE_WIDTH-1:0] a,
  input  logic signed [SAMPLE_WIDTH-1:0] b,
  input  logic signed [SAMPLE_WIDTH-1:0] c,
  input  logic signed [SAMPLE_WIDTH-1:0] d,
  input  logic signed [SAMPLE_WIDTH-1:0] e,
  output logic signed [SAMPLE_WIDTH-1:0] res
);
  import wenoz_pkg::*;
  localparam int NW = SAMPLE_WIDTH + 6;
  localparam int PW = NW + WEIGHT_BITS + 2;
  localparam int LAT_DIV1 = B_W + IND_FRAC;
  localparam int AW = 66;
  localparam int LAT_DIV2 = AW + WEIGHT_BITS;
  localparam int DLY = 4 + LAT_DIV1 + 2 + LAT_DIV2;
  localparam int DK = SAMPLE_WIDTH + 3 + ((((SAMPLE_WIDTH + 3) % 2) == 0) ? 1 : 0);
  localparam logic [DK-1:0] RECIP = DK'(((64'd1 << DK) + 64'd1) / 64'd3);
  localparam logic signed [PW+1:0] HALF  = (PW+2)'(64'd1 << (SAMPLE_WIDTH - 1));
  localparam logic signed [PW+1:0] FV_HI = 6 * HALF - 1;
  localparam logic signed [PW+1:0] FV_LO = -6 * HALF;
  localparam logic signed [PW+1:0] FD_HI = 8 * HALF - 1;
  localparam logic signed [PW+1:0] FD_LO = -8 * HALF;
  localparam logic signed [PW+1:0] OFS   = 3 * HALF;

  // stage 1: candidates and differences
  logic signed [NW-1:0] n0_r, n1_r, n2_r;
  logic [NW-1:0]        m_r [6];
  logic                 fd1_r;
  logic signed [NW-1:0] xa, xb, xc, xd, xe, s [6];
  always_comb begin
    xa = NW'(a); xb = NW'(b); xc = NW'(c); xd = NW'(d); xe = NW'(e);
    s[0] = xa - 2*xb + xc;  s[1] = xa - 4*xb + 3*xc;
    s[2] = xb - 2*xc + xd;  s[3] = xb - xd;
    s[4] = xc - 2*xd + xe;  s[5] = 3*xc - 4*xd + xe;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      fd1_r <= fd;
      if (fd) begin
        n0_r <= 3*xa - 10*xb + 15*xc;
        n1_r <= -xb + 6*xc + 3*xd;
        n2_r <= 3*xc + 6*xd - xe;
      end else begin
        n0_r <= 2*xa - 7*xb + 11*xc;
        n1_r <= -xb + 5*xc + 2*xd;
        n2_r <= 2*xc + 5*xd - xe;
      end
      for (int k = 0; k < 6; k++) m_r[k] <= s[k][NW-1] ? NW'(-s[k]) : NW'(s[k]);
    end
  end

  // stage 2: block scaling
  logic [MAG_LIMIT-1:0] u_r [6];
  logic [NW-1:0] orv;
  logic [7:0]    sh;
  always_comb begin
    orv = '0;
    for (int k = 0; k < 6; k++) orv |= m_r[k];
    sh = '0;
    for (int i = MAG_LIMIT; i < NW; i++) if (orv[i]) sh = 8'(i - MAG_LIMIT + 1);
  end
  always_ff @(posedge clk) begin
    if (adv) for (int k = 0; k < 6; k++) u_r[k] <= MAG_LIMIT'(m_r[k] >> sh);
  end

  // stage 3: squares
  logic [2*MAG_LIMIT-1:0] sq_r [6];
  always_ff @(posedge clk) begin
    if (adv) for (int k = 0; k < 6; k++) sq_r[k] <= u_r[k] * u_r[k];
  end

  // stage 4: smoothness measures
  logic [B_W-1:0] bm_r [3];
  always_ff @(posedge clk) begin
    if (adv) for (int k = 0; k < 3; k++)
      bm_r[k] <= 13 * B_W'(sq_r[2*k]) + 3 * B_W'(sq_r[2*k+1]);
  end

  // stage 5: tau
  logic [B_W-1:0] tau_r, den_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      tau_r <= (bm_r[0] > bm_r[2]) ? bm_r[0] - bm_r[2] : bm_r[2] - bm_r[0];
      for (int k = 0; k < 3; k++) den_r[k] <= bm_r[k] + 1'b1;
    end
  end

  // indicator dividers
  logic [30:0] g [3];
  for (genvar k = 0; k < 3; k++) begin : g_ind
    wenoz_divider #(.NW(B_W), .DW(B_W), .FB(IND_FRAC), .CW(31)) u_div (
      .clk, .adv, .num(tau_r), .den(den_r[k]), .cap(31'h3fff_ffff), .quo(g[k]));
  end

  // fd travels alongside
  logic fd_d_r [LAT_DIV1+4];
  always_ff @(posedge clk) begin
    if (adv) begin
      fd_d_r[0] <= fd1_r;
      for (int i = 1; i < LAT_DIV1 + 4; i++) fd_d_r[i] <= fd_d_r[i-1];
    end
  end
  logic fd_g;
  assign fd_g = fd_d_r[LAT_DIV1+3];

  // alpha: square then scale
  logic [61:0] gsq_r [3];
  logic        fda_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) gsq_r[k] <= g[k][29:0] * g[k][29:0];
      fda_r <= fd_g;
    end
  end
  logic [AW-1:0] al_r [3], asum;
  logic [AW-1:0] base [3];
  always_comb begin
    for (int k = 0; k < 3; k++) base[k] = AW'(({1'b1, 32'h0} + 63'(gsq_r[k])) >> 2);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      al_r[0] <= base[0];
      al_r[1] <= fda_r ? 10 * base[1] : 6 * base[1];
      al_r[2] <= fda_r ? 5 * base[2] : 3 * base[2];
    end
  end
  assign asum = al_r[0] + al_r[1] + al_r[2];

  logic [WEIGHT_BITS:0] w0, w2;
  wenoz_divider #(.NW(AW), .DW(AW), .FB(WEIGHT_BITS), .CW(WEIGHT_BITS+1)) u_w0 (
    .clk, .adv, .num(al_r[0]), .den(asum), .cap({1'b1, {WEIGHT_BITS{1'b0}}}), .quo(w0));
  wenoz_divider #(.NW(AW), .DW(AW), .FB(WEIGHT_BITS), .CW(WEIGHT_BITS+1)) u_w2 (
    .clk, .adv, .num(al_r[2]), .den(asum), .cap({1'b1, {WEIGHT_BITS{1'b0}}}), .quo(w2));

  // candidates and mode delayed to meet the weights
  logic signed [NW-1:0] nd_r [DLY][3];
  logic                 fdd_r [DLY];
  always_ff @(posedge clk) begin
    if (adv) begin
      nd_r[0][0] <= n0_r; nd_r[0][1] <= n1_r; nd_r[0][2] <= n2_r;
      fdd_r[0] <= fd1_r;
      for (int i = 1; i < DLY; i++) begin
        nd_r[i] <= nd_r[i-1];
        fdd_r[i] <= fdd_r[i-1];
      end
    end
  end

  // blend products
  logic signed [PW-1:0] p_r [3];
  logic                 fdb_r;
  logic [WEIGHT_BITS:0] w1;
  assign w1 = (WEIGHT_BITS+1)'({1'b1, {WEIGHT_BITS{1'b0}}} - w0 - w2);
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= nd_r[DLY-1][0] * $signed({1'b0, w0});
      p_r[1] <= nd_r[DLY-1][1] * $signed({1'b0, w1});
      p_r[2] <= nd_r[DLY-1][2] * $signed({1'b0, w2});
      fdb_r  <= fdd_r[DLY-1];
    end
  end

  // sum, add half the divisor, clamp so the quotient lands inside the sample range
  logic signed [PW+1:0] tot, q, z, zc;
  always_comb begin
    tot = (PW+2)'(p_r[0]) + (PW+2)'(p_r[1]) + (PW+2)'(p_r[2]);
    q   = tot >>> WEIGHT_BITS;
    z   = q + (fdb_r ? (PW+2)'(4) : (PW+2)'(3));
    zc  = z;
    if (fdb_r) begin
      if (z > FD_HI) zc = FD_HI;
      if (z < FD_LO) zc = FD_LO;
    end else begin
      if (z > FV_HI) zc = FV_HI;
      if (z < FV_LO) zc = FV_LO;
    end
  end

  // finite difference divides by eight; finite volume keeps half, offset to non-negative
  logic [SAMPLE_WIDTH+1:0] hv_r;
  logic [SAMPLE_WIDTH-1:0] fdq_r;
  logic                    fdc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      hv_r  <= (SAMPLE_WIDTH+2)'((zc >>> 1) + OFS);
      fdq_r <= SAMPLE_WIDTH'(zc >>> 3);
      fdc_r <= fdb_r;
    end
  end

  // divide by three with a reciprocal multiply; the offset returns as a sign-bit flip
  logic [SAMPLE_WIDTH+DK+1:0] prod;
  logic [SAMPLE_WIDTH-1:0]    third;
  always_comb begin
    prod  = (SAMPLE_WIDTH+DK+2)'(hv_r) * (SAMPLE_WIDTH+DK+2)'(RECIP);
    third = prod[DK +: SAMPLE_WIDTH];
  end
  always_ff @(posedge clk) begin
    if (adv) res <= fdc_r ? fdq_r : {~third[SAMPLE_WIDTH-1], third[SAMPLE_WIDTH-2:0]};
  end
endmodule

// ===== hdl/wenoz_fifth_order_reconstruct.sv =====
// Top level: WENO-Z+ fifth-order face reconstruction pipeline.
// The pipeline has five front stages, an 80-stage indicator divider, two alpha stages,
// a 96-stage weight divider and three blend and rounding stages.
// Throughput: one stencil request per cycle; a held result freezes the whole pipeline.
// Reset: rst_n synchronous, clears valid bits and mode register (finite volume).
// Result register holds while out_valid and out_stall are both high; nothing is lost or repeated.
module wenoz_fifth_order_reconstruct (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wenoz_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wenoz_pkg::out_req_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_data
);
  import wenoz_pkg::*;
  localparam int LAT = 5 + 80 + 2 + 96 + 3;

  logic fd_r, adv;
  logic vld_r [LAT];

  // advance everything unless the output is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r <= 1'b0;
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      if (cfg_valid) fd_r <= cfg_data[0];
      if (adv) begin
        vld_r[0] <= in_valid;
        for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  logic signed [SW-1:0] up, lo;
  // upper face: forward stencil
  wenoz_face #(.SAMPLE_WIDTH(SW)) u_up (
    .clk, .adv, .fd(fd_r),
    .a(in_data.sample_minus_two), .b(in_data.sample_minus_one),
    .c(in_data.sample_centre), .d(in_data.sample_plus_one),
    .e(in_data.sample_plus_two), .res(up));
  // lower face: reversed stencil
  wenoz_face #(.SAMPLE_WIDTH(SW)) u_lo (
    .clk, .adv, .fd(fd_r),
    .a(in_data.sample_plus_two), .b(in_data.sample_plus_one),
    .c(in_data.sample_centre), .d(in_data.sample_minus_one),
    .e(in_data.sample_minus_two), .res(lo));

  assign out_data.upper_face_value = up;
  assign out_data.lower_face_value = lo;
endmodule

// ===== dv/wenoz_face_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the WENO-Z+ face pipeline: predicts face values and compares results.
module wenoz_face_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  wenoz_pkg::in_req_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  wenoz_pkg::out_req_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  fail_count = 0,
  output int                  faces_pending
);
  import wenoz_pkg::*;

  localparam logic [63:0] GAIN_CAP   = (64'd1 << 30) - 64'd1;
  localparam logic [63:0] WEIGHT_ONE = 64'd1 << WEIGHT_BITS;

  logic     fd_mode;
  out_req_t faces_due[$];

  function automatic logic [63:0] abs_diff(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // floor(num * 2^fb / den), clamped to cap
  function automatic logic [63:0] frac_quot(input logic [63:0] num, input logic [63:0] den,
                                            input int fb, input logic [63:0] cap);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    if (q > cap) return cap;
    for (int i = 0; i < fb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic logic signed [SW-1:0] face_value(input longint a, input longint b,
                                                      input longint c, input longint d,
                                                      input longint e, input logic fd);
    longint cand[3];
    longint lin[3];
    longint den;
    logic [63:0] m[6];
    logic [63:0] mall, tau, g, asum;
    logic [63:0] smooth[3];
    logic [63:0] alpha[3];
    logic [63:0] w[3];
    logic signed [127:0] acc, q, num, wide_den, res;
    int sh;
    if (fd) begin
      cand[0] = 3*a - 10*b + 15*c;
      cand[1] = -b + 6*c + 3*d;
      cand[2] = 3*c + 6*d - e;
      lin = '{1, 10, 5};
      den = 8;
    end else begin
      cand[0] = 2*a - 7*b + 11*c;
      cand[1] = -b + 5*c + 2*d;
      cand[2] = 2*c + 5*d - e;
      lin = '{1, 6, 3};
      den = 6;
    end
    m[0] = abs_diff(a - 2*b + c);
    m[1] = abs_diff(a - 4*b + 3*c);
    m[2] = abs_diff(b - 2*c + d);
    m[3] = abs_diff(b - d);
    m[4] = abs_diff(c - 2*d + e);
    m[5] = abs_diff(3*c - 4*d + e);
    mall = 0;
    for (int k = 0; k < 6; k++) mall |= m[k];
    // block scaling: one shift for all three measures
    sh = 0;
    while ((mall >> sh) >= (64'd1 << MAG_LIMIT)) sh++;
    for (int k = 0; k < 6; k++) m[k] = m[k] >> sh;
    for (int k = 0; k < 3; k++) smooth[k] = 13*m[2*k]*m[2*k] + 3*m[2*k+1]*m[2*k+1];
    tau = smooth[0] > smooth[2] ? smooth[0] - smooth[2] : smooth[2] - smooth[0];
    asum = 0;
    for (int k = 0; k < 3; k++) begin
      g = frac_quot(tau, smooth[k] + 64'd1, IND_FRAC, GAIN_CAP);
      alpha[k] = 64'(lin[k]) * (((64'd1 << 32) + g*g) >> 2);
      asum += alpha[k];
    end
    w[0] = frac_quot(alpha[0], asum, WEIGHT_BITS, WEIGHT_ONE);
    w[2] = frac_quot(alpha[2], asum, WEIGHT_BITS, WEIGHT_ONE);
    w[1] = WEIGHT_ONE - w[0] - w[2];
    acc = 0;
    for (int k = 0; k < 3; k++) acc += 128'(cand[k]) * $signed({64'd0, w[k]});
    q = acc >>> WEIGHT_BITS;
    num = 2*q + den;
    wide_den = 2*den;
    // round half up via floor division
    res = num >= 0 ? num / wide_den : -((-num + wide_den - 1) / wide_den);
    if (res > 128'sd2147483647) res = 128'sd2147483647;
    if (res < -128'sd2147483648) res = -128'sd2147483648;
    return res[SW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign faces_pending = faces_due.size();

  always @(posedge clk) begin
    out_req_t exp_f;
    if (!rst_n) begin
      fd_mode <= 1'b0;
      faces_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) fd_mode <= cfg_data;
      if (in_valid && !in_stall) begin
        exp_f.upper_face_value = face_value(in_data.sample_minus_two,
          in_data.sample_minus_one, in_data.sample_centre, in_data.sample_plus_one,
          in_data.sample_plus_two, fd_mode);
        exp_f.lower_face_value = face_value(in_data.sample_plus_two,
          in_data.sample_plus_one, in_data.sample_centre, in_data.sample_minus_one,
          in_data.sample_minus_two, fd_mode);
        faces_due.push_back(exp_f);
      end
      if (out_valid && !out_stall) begin
        if (faces_due.size() == 0) begin
          report_mismatch("unexpected request", 0, 0);
        end else begin
          exp_f = faces_due.pop_front();
          if (out_data.upper_face_value !== exp_f.upper_face_value)
            report_mismatch("upper face", out_data.upper_face_value, exp_f.upper_face_value);
          if (out_data.lower_face_value !== exp_f.lower_face_value)
            report_mismatch("lower face", out_data.lower_face_value, exp_f.lower_face_value);
        end
      end
    end
  end

endmodule

// ===== dv/wenoz_fifth_order_reconstruct_tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench: stencil stimulus, flow control, mode writes and verdict.
module wenoz_fifth_order_reconstruct_tb;
  import wenoz_pkg::*;

  localparam int RANDOM_STENCILS = 1200;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;
  int       fail_count;
  int       faces_pending;

  // idle percentages for each side, changed per phase
  int       tx_idle_pct;
  int       rx_idle_pct;
  // request for a long receiver hold-off, served by the receiver process
  bit       hold_req;
  int       hold_left;

  wenoz_fifth_order_reconstruct dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  wenoz_face_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .faces_pending(faces_pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Guard against a hung pipeline; far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when asked for one.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 600;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offer one request and hold it until accepted; valid stays high for the next one unless the sender idles.
  task automatic send_stencil(input in_req_t st);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= st;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected face pair has come back.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (faces_pending != 0) @(posedge clk);
  endtask

  // Mode changes only while the pipeline is empty.
  task automatic write_mode(input logic fd);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data  <= fd;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_req_t pack_stencil(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d,
                                           input logic [31:0] e);
    in_req_t st;
    st.sample_minus_two = a;
    st.sample_minus_one = b;
    st.sample_centre    = c;
    st.sample_plus_one  = d;
    st.sample_plus_two  = e;
    return st;
  endfunction

  // Random stencil: mostly smooth profiles, some shocks, some raw full-range noise.
  function automatic in_req_t random_stencil();
    int kind;
    longint base, slope, curv, v;
    logic [31:0] s[5];
    kind = $urandom_range(99);
    if (kind < 20) begin
      for (int i = 0; i < 5; i++) s[i] = $urandom;
    end else begin
      base  = $signed(32'($urandom)) >>> $urandom_range(0, 8);
      slope = $signed(32'($urandom)) >>> $urandom_range(8, 31);
      curv  = $signed(32'($urandom)) >>> $urandom_range(12, 31);
      for (int i = 0; i < 5; i++) begin
        v = base + slope*(i-2) + curv*(i-2)*(i-2) + $signed($urandom_range(0, 15)) - 8;
        // shock: jump from the chosen cell onwards
        if (kind >= 80 && i >= 2 + (kind % 3) - 1) v += $signed(32'($urandom)) >>> 2;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        s[i] = v[31:0];
      end
    end
    return pack_stencil(s[0], s[1], s[2], s[3], s[4]);
  endfunction

  // Extremes, flat data, ramps, saturation and big-indicator cases.
  task automatic send_directed();
    send_stencil(pack_stencil(0, 0, 0, 0, 0));
    send_stencil(pack_stencil(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff));
    send_stencil(pack_stencil(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000));
    send_stencil(pack_stencil(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
                              32'h00010000));
    send_stencil(pack_stencil(32'hfffe0000, 32'hffff0000, 0, 32'h00010000, 32'h00020000));
    send_stencil(pack_stencil(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000));
    send_stencil(pack_stencil(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff));
    send_stencil(pack_stencil(0, 0, 0, 32'h7fffffff, 32'h7fffffff));
    send_stencil(pack_stencil(0, 0, 1, 0, 0));
    send_stencil(pack_stencil(5, 5, 5, 5, 32'h40000000));
    send_stencil(pack_stencil(32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000));
    send_stencil(pack_stencil(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0));
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    hold_req    = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed set in both coefficient modes
    write_mode(1'b0);
    send_directed();
    write_mode(1'b1);
    send_directed();

    // phase one: sender idles often, receiver stalls mostly
    write_mode(1'b0);
    tx_idle_pct = 34;
    rx_idle_pct = 79;
    for (int i = 0; i < RANDOM_STENCILS / 3; i++) send_stencil(random_stencil());

    // phase two: the other way round
    write_mode(1'b1);
    tx_idle_pct = 79;
    rx_idle_pct = 34;
    for (int i = 0; i < RANDOM_STENCILS / 3; i++) send_stencil(random_stencil());

    // phase three: no idling; open with a long hold-off so the pipe fills and backs up
    write_mode(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_STENCILS / 3; i++) begin
      if (i == RANDOM_STENCILS / 6) write_mode(1'b1);
      send_stencil(random_stencil());
    end

    drain_pipe();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
